@@ rtl/tqr_pkg.sv @@
// types and constants shared by the tile quarter-turn rotator
package tqr_pkg;

  localparam int unsigned PIXEL_BITS           = 16;
  localparam int unsigned MAX_TILE_PIXELS_DEF  = 16384;
  localparam int unsigned DIM_W                = 11;
  localparam int unsigned COORD_W              = 10;
  localparam int unsigned NATIVE_W             = 12;
  localparam int unsigned INDEX_W              = 14;
  localparam int unsigned CFG_DATA_W           = 11;
  localparam int unsigned CFG_INDEX_W          = 2;
  localparam logic [DIM_W-1:0] MAX_DIM         = 11'd1024;
  localparam logic [DIM_W-1:0] PANEL_RESET     = 11'd1024;

  typedef enum logic [1:0] {
    ROT_0   = 2'd0,
    ROT_90  = 2'd1,
    ROT_180 = 2'd2,
    ROT_270 = 2'd3
  } rot_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_ROTATION = 2'd0,
    CFG_PANEL_W  = 2'd1,
    CFG_PANEL_H  = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic [PIXEL_BITS-1:0] pixel;
    logic                  first;
    logic [COORD_W-1:0]    tile_x;
    logic [COORD_W-1:0]    tile_y;
    logic [DIM_W-1:0]      tile_w;
    logic [DIM_W-1:0]      tile_h;
  } tqr_in_t;

  typedef struct packed {
    logic [PIXEL_BITS-1:0]     out_pixel;
    logic [INDEX_W-1:0]        dst_index;
    logic signed [NATIVE_W-1:0] out_x;
    logic signed [NATIVE_W-1:0] out_y;
    logic [DIM_W-1:0]          out_w;
    logic [DIM_W-1:0]          out_h;
    logic                      last;
    logic                      area_error;
  } tqr_out_t;

endpackage

@@ rtl/tile_quarter_turn_rotator.sv @@
// tile quarter-turn rotator: destination index and native rectangle per pixel
// a request passes through the input register and then the result register
// throughput: one pixel per cycle unless out_stall holds the result; the index uses one
//   14x11 multiply and the area check one 11x11 multiply, both in the single compute stage
// reset (rst_n low, synchronous): rotation 0, panel 1024 x 1024, counters zero,
//   held tile 1 x 1 at (0, 0), both pipeline stages empty
module tile_quarter_turn_rotator #(
  parameter int unsigned MAX_TILE_PIXELS = tqr_pkg::MAX_TILE_PIXELS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // pixel requests
  input  logic                                in_valid,
  output logic                                in_stall,
  input  tqr_pkg::tqr_in_t                    in_data,
  // results
  output logic                                out_valid,
  input  logic                                out_stall,
  output tqr_pkg::tqr_out_t                   out_data,
  // configuration writes
  input  logic                                cfg_we,
  input  logic [tqr_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [tqr_pkg::CFG_DATA_W-1:0]      cfg_data
);

  import tqr_pkg::*;

  localparam int unsigned AREA_W = 2 * DIM_W;
  localparam int unsigned PROD_W = INDEX_W + DIM_W;

  // configuration registers
  rot_t             rot_r;
  logic [DIM_W-1:0] panel_w_r;
  logic [DIM_W-1:0] panel_h_r;

  // input register
  logic    s1_valid_r;
  tqr_in_t s1_r;

  // result register
  logic     out_valid_r;
  tqr_out_t out_r;
  tqr_out_t out_nxt;

  // tile walk state
  logic [COORD_W-1:0]  col_r, col_nxt;
  logic [COORD_W-1:0]  row_r, row_nxt;
  logic [INDEX_W-1:0]  lin_r, lin_nxt;
  logic [DIM_W-1:0]    held_w_r, held_h_r;
  logic [NATIVE_W-1:0] held_x_r, held_y_r;

  // compute stage signals
  logic                advance;
  logic                fire;
  logic                fst;
  logic [DIM_W-1:0]    new_w, new_h;
  logic [DIM_W-1:0]    w, h;
  logic [COORD_W-1:0]  c, r;
  logic [INDEX_W-1:0]  lin;
  logic [NATIVE_W-1:0] x12, y12, w12, h12, pw12, ph12;
  logic [NATIVE_W-1:0] new_x, new_y;
  logic [INDEX_W-1:0]  c14, r14, w14, h14;
  logic [INDEX_W-1:0]  mul_a;
  logic [PROD_W-1:0]   idx_prod;
  logic [AREA_W-1:0]   area;
  logic [INDEX_W-1:0]  idx;
  logic [DIM_W-1:0]    c_inc, r_inc;
  logic                row_end;
  logic                last;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
    logic [DIM_W-1:0] res;
    if (v == '0) begin
      res = {{(DIM_W-1){1'b0}}, 1'b1};
    end else if (v > MAX_DIM) begin
      res = MAX_DIM;
    end else begin
      res = v;
    end
    return res;
  endfunction

  // the compute stage moves whenever the result register is free or being emptied
  assign advance   = !out_valid_r || !out_stall;
  assign fire      = s1_valid_r && advance;
  assign in_stall  = s1_valid_r && !advance;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // rectangle of the current pixel: freshly latched on first, held otherwise
  always_comb begin
    fst   = s1_r.first;
    new_w = clamp_dim(s1_r.tile_w);
    new_h = clamp_dim(s1_r.tile_h);
    w     = fst ? new_w : held_w_r;
    h     = fst ? new_h : held_h_r;
    c     = fst ? '0 : col_r;
    r     = fst ? '0 : row_r;
    lin   = fst ? '0 : lin_r;
  end

  // tile origin mapped back to native panel space, 12-bit wrap
  always_comb begin
    x12  = {{(NATIVE_W-COORD_W){1'b0}}, s1_r.tile_x};
    y12  = {{(NATIVE_W-COORD_W){1'b0}}, s1_r.tile_y};
    w12  = {{(NATIVE_W-DIM_W){1'b0}}, new_w};
    h12  = {{(NATIVE_W-DIM_W){1'b0}}, new_h};
    pw12 = {{(NATIVE_W-DIM_W){1'b0}}, panel_w_r};
    ph12 = {{(NATIVE_W-DIM_W){1'b0}}, panel_h_r};
    case (rot_r)
      ROT_90: begin
        new_x = pw12 - y12 - h12;
        new_y = x12;
      end
      ROT_180: begin
        new_x = pw12 - x12 - w12;
        new_y = ph12 - y12 - h12;
      end
      ROT_270: begin
        new_x = y12;
        new_y = ph12 - x12 - w12;
      end
      default: begin
        new_x = x12;
        new_y = y12;
      end
    endcase
  end

  // destination index, all arithmetic modulo 2^14
  always_comb begin
    c14 = {{(INDEX_W-COORD_W){1'b0}}, c};
    r14 = {{(INDEX_W-COORD_W){1'b0}}, r};
    w14 = {{(INDEX_W-DIM_W){1'b0}}, w};
    h14 = {{(INDEX_W-DIM_W){1'b0}}, h};
    // 90 cw walks columns of the source as rows; 270 walks them mirrored
    mul_a    = (rot_r == ROT_90) ? c14 : (w14 - {{(INDEX_W-1){1'b0}}, 1'b1} - c14);
    idx_prod = PROD_W'(mul_a) * PROD_W'(h);
    area     = AREA_W'(w) * AREA_W'(h);
    case (rot_r)
      ROT_90:  idx = idx_prod[INDEX_W-1:0] + h14 - {{(INDEX_W-1){1'b0}}, 1'b1} - r14;
      ROT_180: idx = area[INDEX_W-1:0] - {{(INDEX_W-1){1'b0}}, 1'b1} - lin;
      ROT_270: idx = idx_prod[INDEX_W-1:0] + r14;
      default: idx = lin;
    endcase
  end

  // end of row / end of tile and the next walk position
  always_comb begin
    c_inc   = {1'b0, c} + {{(DIM_W-1){1'b0}}, 1'b1};
    r_inc   = {1'b0, r} + {{(DIM_W-1){1'b0}}, 1'b1};
    row_end = (c_inc >= w);
    last    = row_end && (r_inc >= h);
    if (last) begin
      col_nxt = '0;
      row_nxt = '0;
      lin_nxt = '0;
    end else begin
      if (row_end) begin
        col_nxt = '0;
        row_nxt = r_inc[COORD_W-1:0];
      end else begin
        col_nxt = c_inc[COORD_W-1:0];
        row_nxt = r;
      end
      lin_nxt = lin + {{(INDEX_W-1){1'b0}}, 1'b1};
    end
  end

  // result assembly; width and height swap for the quarter turns
  always_comb begin
    out_nxt.out_pixel  = s1_r.pixel;
    out_nxt.dst_index  = idx;
    out_nxt.out_x      = fst ? new_x : held_x_r;
    out_nxt.out_y      = fst ? new_y : held_y_r;
    if (rot_r == ROT_90 || rot_r == ROT_270) begin
      out_nxt.out_w = h;
      out_nxt.out_h = w;
    end else begin
      out_nxt.out_w = w;
      out_nxt.out_h = h;
    end
    out_nxt.last       = last;
    out_nxt.area_error = (area > AREA_W'(MAX_TILE_PIXELS));
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rot_r     <= ROT_0;
      panel_w_r <= PANEL_RESET;
      panel_h_r <= PANEL_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ROTATION: rot_r     <= rot_t'(cfg_data[1:0]);
        CFG_PANEL_W:  panel_w_r <= cfg_data;
        CFG_PANEL_H:  panel_h_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // pipeline valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (!in_stall) begin
        s1_valid_r <= in_valid;
      end
      if (advance) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  // pipeline payload
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_r <= in_data;
    end
    if (fire) begin
      out_r <= out_nxt;
    end
  end

  // tile walk state, updated as each pixel leaves the compute stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r    <= '0;
      row_r    <= '0;
      lin_r    <= '0;
      held_w_r <= {{(DIM_W-1){1'b0}}, 1'b1};
      held_h_r <= {{(DIM_W-1){1'b0}}, 1'b1};
      held_x_r <= '0;
      held_y_r <= '0;
    end else if (fire) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
      lin_r <= lin_nxt;
      if (fst) begin
        held_w_r <= new_w;
        held_h_r <= new_h;
        held_x_r <= new_x;
        held_y_r <= new_y;
      end
    end
  end

endmodule
